// ===== src/acbo_pkg.sv =====
`timescale 1ns / 1ps

package acbo_pkg;

  // Most run bytes sent after the flushed byte; the rest of a long run is dropped.
  localparam int RepeatLimit = 8;
  localparam int RepWidth    = $clog2(RepeatLimit + 1);

  // Job queue between the front and the back.
  localparam int JobDepth    = 4;
  localparam int JobPtrWidth = $clog2(JobDepth);
  localparam int JobCntWidth = $clog2(JobDepth + 1);

  localparam logic [1:0] CmdStart  = 2'd0;
  localparam logic [1:0] CmdStop   = 2'd1;
  localparam logic [1:0] CmdUpdate = 2'd2;

  localparam logic KindByte   = 1'b0;
  localparam logic KindReport = 1'b1;

  localparam logic [5:0]  ExtractBelow = 6'd12;
  localparam logic [4:0]  LeadBase     = 5'd24;
  localparam logic [5:0]  BitsRefill   = 6'd8;
  localparam logic [31:0] LowMask      = 32'h00ff_ffff;
  localparam logic [7:0]  EscByte      = 8'h03;
  localparam logic [7:0]  FfByte       = 8'hff;
  localparam logic [7:0]  ZeroByte     = 8'h00;
  localparam logic [1:0]  ZeroRunMax   = 2'd2;

  typedef enum logic [1:0] {
    JobStart,
    JobStop,
    JobBurst
  } job_kind_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [23:0] low_add;
    logic [3:0]  shift_amount;
    logic        add_first;
    logic [31:0] init_low;
    logic [5:0]  init_bits_left;
    logic [7:0]  init_pending_byte;
    logic [7:0]  init_pending_count;
    logic [1:0]  init_zero_run;
    logic [4:0]  stream_id;
  } acbo_in_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        last;
    logic [31:0] final_low;
    logic [5:0]  final_bits_left;
    logic [7:0]  final_pending_byte;
    logic [7:0]  final_pending_count;
    logic [1:0]  final_zero_run;
    logic [15:0] final_length;
    logic [4:0]  done_stream_id;
  } acbo_out_t;

  typedef struct packed {
    job_kind_e           kind;
    logic [7:0]          first_byte;
    logic [7:0]          run_byte;
    logic [RepWidth-1:0] reps;
    logic [31:0]         low;
    logic [5:0]          bits_avail;
    logic [7:0]          held_byte;
    logic [7:0]          pending_count;
    logic [1:0]          zero_run;
    logic [4:0]          stream_id;
  } acbo_job_t;

endpackage

// ===== src/arith_coder_byte_output_top.sv =====
`timescale 1ns / 1ps

// Byte output stage of a CABAC arithmetic coder.
// Input channel (push/full): one command word per handshake; start loads the
// coder state, update shifts and adds into low and may extract a lead byte,
// stop asks for a report of the final state.
// Result channel (empty/pop): the oldest result word sits on out_word_o while
// empty is low; an update yields up to 18 byte words (flushed byte, run bytes,
// and 0x03 escapes after two zero bytes), a stop yields one report word.
// The last word caused by one command carries last.
// Flow: full stays high from an accept until that command is done (the low
// update is registered on accept, then the lead byte is extracted and a job
// queued), so the front takes no new command meanwhile. The back sends one
// result word per cycle while pop is high, from a 4-deep job queue.
// Stalls: while pop is low the back holds its output word, the job queue
// fills and full then rises on the front.
// Reset clears all coder state to zero and empties both queues.
module arith_coder_byte_output_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  acbo_pkg::acbo_in_t  in_word_i,
  output logic                empty,
  input  logic                pop,
  output acbo_pkg::acbo_out_t out_word_o
);
  import acbo_pkg::*;

  // Jobs from the front to the back.
  logic      job_push;
  logic      job_full;
  logic      job_pop;
  logic      job_empty;
  acbo_job_t job_in;
  acbo_job_t job_head;

  // Front: hold coder low, bits left, held byte and run length; classify.
  acbo_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (full),
    .in_word_i  (in_word_i),
    .job_full_i (job_full),
    .job_push_o (job_push),
    .job_o      (job_in)
  );

  // Short queue so a burst of bytes does not stall the front.
  acbo_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .head_o  (job_head)
  );

  // Back: expand jobs into byte words, insert escapes, count bytes.
  acbo_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_head),
    .job_pop_o   (job_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_word_o  (out_word_o)
  );

endmodule

// ===== src/acbo_front.sv =====
`timescale 1ns / 1ps

module acbo_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  acbo_pkg::acbo_in_t in_word_i,
  input  logic               job_full_i,
  output logic               job_push_o,
  output acbo_pkg::acbo_job_t job_o
);
  import acbo_pkg::*;

  logic        pend_q;
  logic [1:0]  cmd_q;
  logic [1:0]  zr_init_q;
  logic        ext_q;
  logic [4:0]  lead_sh_q;
  logic [3:0]  mask_sh_q;
  logic [31:0] low_q;
  logic [5:0]  bits_q;
  logic [7:0]  held_q;
  logic [7:0]  outst_q;
  logic [4:0]  stream_q;

  logic                accept;
  logic                done;
  logic                need_push;
  logic [5:0]          br_new;
  logic                ext_new;
  logic [31:0]         add_ext;
  logic [31:0]         sum_pre;
  logic [31:0]         low_new;
  logic [31:0]         lead_wide;
  logic [8:0]          lead;
  logic [7:0]          reps_raw;
  logic [RepWidth-1:0] reps;
  logic                lead_is_ff;

  assign accept  = push_i && !pend_q;
  assign full_o  = pend_q;

  // Low update on the accepting edge, straight from the input word.
  assign br_new  = bits_q - {2'b00, in_word_i.shift_amount};
  assign ext_new = br_new < ExtractBelow;
  assign add_ext = {8'h00, in_word_i.low_add};
  assign sum_pre = low_q + add_ext;

  always_comb begin
    if (in_word_i.add_first) begin
      low_new = sum_pre << in_word_i.shift_amount;
    end else begin
      low_new = (low_q << in_word_i.shift_amount) + add_ext;
    end
  end

  // Lead byte extraction on the following cycle.
  assign lead_wide  = low_q >> lead_sh_q;
  assign lead       = lead_wide[8:0];
  assign lead_is_ff = (lead == {1'b0, FfByte});
  assign reps_raw   = outst_q - 8'd1;
  assign reps       = (reps_raw > 8'(RepeatLimit)) ? RepWidth'(RepeatLimit)
                                                   : RepWidth'(reps_raw);

  always_comb begin
    need_push = 1'b0;
    case (cmd_q)
      CmdStart:  need_push = 1'b1;
      CmdStop:   need_push = 1'b1;
      CmdUpdate: need_push = ext_q && !lead_is_ff && (outst_q != 8'd0);
      default:   need_push = 1'b0;
    endcase
  end

  assign done       = pend_q && (!need_push || !job_full_i);
  assign job_push_o = pend_q && need_push && !job_full_i;

  always_comb begin
    job_o               = '0;
    job_o.kind          = JobBurst;
    case (cmd_q)
      CmdStart: job_o.kind = JobStart;
      CmdStop:  job_o.kind = JobStop;
      default:  job_o.kind = JobBurst;
    endcase
    job_o.first_byte    = held_q + {7'd0, lead[8]};
    job_o.run_byte      = lead[8] ? ZeroByte : FfByte;
    job_o.reps          = reps;
    job_o.low           = low_q;
    job_o.bits_avail    = bits_q;
    job_o.held_byte     = held_q;
    job_o.pending_count = outst_q;
    job_o.zero_run      = zr_init_q;
    job_o.stream_id     = stream_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      low_q    <= '0;
      bits_q   <= '0;
      held_q   <= '0;
      outst_q  <= '0;
      stream_q <= '0;
    end else if (accept) begin
      pend_q <= 1'b1;
      case (in_word_i.command)
        CmdStart: begin
          low_q    <= in_word_i.init_low;
          bits_q   <= in_word_i.init_bits_left;
          held_q   <= in_word_i.init_pending_byte;
          outst_q  <= in_word_i.init_pending_count;
          stream_q <= in_word_i.stream_id;
        end
        CmdUpdate: begin
          low_q  <= low_new;
          bits_q <= ext_new ? (br_new + BitsRefill) : br_new;
        end
        default: begin
        end
      endcase
    end else if (done) begin
      pend_q <= 1'b0;
      if (cmd_q == CmdUpdate && ext_q) begin
        low_q <= low_q & (LowMask >> mask_sh_q);
        if (lead_is_ff) begin
          outst_q <= outst_q + 8'd1;
        end else begin
          held_q  <= lead[7:0];
          outst_q <= 8'd1;
        end
      end
    end
  end

  // Item details registered on accept for the extraction step.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= in_word_i.command;
      zr_init_q <= (in_word_i.init_zero_run > ZeroRunMax) ? ZeroRunMax
                                                          : in_word_i.init_zero_run;
      ext_q     <= ext_new;
      lead_sh_q <= LeadBase - {1'b0, br_new[3:0]};
      mask_sh_q <= br_new[3:0];
    end
  end

endmodule

// ===== src/acbo_job_fifo.sv =====
`timescale 1ns / 1ps

module acbo_job_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  acbo_pkg::acbo_job_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output acbo_pkg::acbo_job_t head_o
);
  import acbo_pkg::*;

  acbo_job_t              slot_q [JobDepth];
  logic [JobPtrWidth-1:0] wr_q;
  logic [JobPtrWidth-1:0] rd_q;
  logic [JobCntWidth-1:0] cnt_q;
  logic                   do_push;
  logic                   do_pop;

  assign full_o  = (cnt_q == JobCntWidth'(JobDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == JobPtrWidth'(JobDepth - 1)) ? '0 : wr_q + JobPtrWidth'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == JobPtrWidth'(JobDepth - 1)) ? '0 : rd_q + JobPtrWidth'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + JobCntWidth'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - JobCntWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== src/acbo_back.sv =====
`timescale 1ns / 1ps

module acbo_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_empty_i,
  input  acbo_pkg::acbo_job_t job_i,
  output logic                job_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output acbo_pkg::acbo_out_t out_word_o
);
  import acbo_pkg::*;

  logic [1:0]          zr_q, zr_d;
  logic [15:0]         len_q, len_d;
  logic [RepWidth-1:0] idx_q, idx_d;
  logic                ins_q, ins_d;
  logic                out_valid_q;
  acbo_out_t           out_q;

  logic      slot_free;
  logic      emit;
  acbo_out_t res;
  logic [7:0] cur_byte;
  logic      last_byte;

  assign slot_free = !out_valid_q || pop_i;
  assign cur_byte  = (idx_q == '0) ? job_i.first_byte : job_i.run_byte;
  assign last_byte = (idx_q == job_i.reps);

  always_comb begin
    job_pop_o = 1'b0;
    emit      = 1'b0;
    res       = '0;
    res.kind  = KindByte;
    zr_d      = zr_q;
    len_d     = len_q;
    idx_d     = idx_q;
    ins_d     = ins_q;
    if (!job_empty_i) begin
      case (job_i.kind)
        JobStart: begin
          job_pop_o = 1'b1;
          zr_d      = job_i.zero_run;
          len_d     = '0;
          idx_d     = '0;
          ins_d     = 1'b0;
        end
        JobStop: begin
          if (slot_free) begin
            emit                    = 1'b1;
            job_pop_o               = 1'b1;
            res.kind                = KindReport;
            res.last                = 1'b1;
            res.final_low           = job_i.low;
            res.final_bits_left     = job_i.bits_avail;
            res.final_pending_byte  = job_i.held_byte;
            res.final_pending_count = job_i.pending_count;
            res.final_zero_run      = zr_q;
            res.final_length        = len_q;
            res.done_stream_id      = job_i.stream_id;
          end
        end
        JobBurst: begin
          if (slot_free) begin
            emit  = 1'b1;
            len_d = len_q + 16'd1;
            if (zr_q == ZeroRunMax && cur_byte[7:2] == 6'd0 && !ins_q) begin
              // Two zero bytes behind a small byte: escape first.
              res.data_byte = EscByte;
              ins_d         = 1'b1;
            end else begin
              res.data_byte = cur_byte;
              res.last      = last_byte;
              ins_d         = 1'b0;
              if (cur_byte != ZeroByte) begin
                zr_d = 2'd0;
              end else if (ins_q) begin
                zr_d = 2'd1;
              end else begin
                zr_d = zr_q + 2'd1;
              end
              if (last_byte) begin
                job_pop_o = 1'b1;
                idx_d     = '0;
              end else begin
                idx_d = idx_q + RepWidth'(1);
              end
            end
          end
        end
        default: begin
          job_pop_o = 1'b1;
        end
      endcase
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_word_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zr_q        <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      zr_q  <= zr_d;
      len_q <= len_d;
      idx_q <= idx_d;
      ins_q <= ins_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

endmodule

// ===== tb/sv/tb_arith_coder_byte_output_top.sv =====
`timescale 1ns / 1ps

module tb_arith_coder_byte_output_top;
  import acbo_pkg::*;

  // The package names no code for the fourth command value; the block ignores it.
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam int HalfPeriod  = 6;
  localparam int CycleLimit  = 2_000_000;
  localparam int RandomItems = 480;
  localparam int LongHold    = 400;   // receiver hold-off, long enough to fill the job queue
  localparam int SettleTail  = 20;    // idle cycles after the last awaited word

  // One row of the directed table. Where typed is set, the expected words are
  // written out in the row (at most one word) instead of coming from the predictor.
  typedef struct {
    acbo_in_t  word;
    bit        typed;
    int        typed_n;
    acbo_out_t typed_w;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  logic      full;
  acbo_in_t  in_word = '0;
  logic      empty;
  logic      pop = 1'b0;
  acbo_out_t out_word;

  // Typed expectation travelling alongside the word currently offered.
  bit        typed_now = 1'b0;
  int        typed_n_now = 0;
  acbo_out_t typed_w_now = '0;

  // Predicted coder state, starting from the reset state.
  logic [31:0] p_low = '0;
  logic [5:0]  p_bits = '0;
  logic [7:0]  p_held = '0;
  logic [7:0]  p_count = '0;
  logic [1:0]  p_zrun = '0;
  logic [15:0] p_len = '0;
  logic [4:0]  p_sid = '0;

  acbo_out_t step_words[$];     // words caused by the command being predicted
  acbo_out_t awaited_words[$];  // words predicted but not yet popped

  int fail_count = 0;
  int words_taken = 0;
  int cycle_count = 0;

  arith_coder_byte_output_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Fill every field at random; callers then overwrite what the command uses.
  function automatic acbo_in_t rand_word();
    acbo_in_t w;
    w.command            = 2'($urandom_range(0, 3));
    w.low_add            = 24'($urandom());
    w.shift_amount       = 4'($urandom_range(0, 15));
    w.add_first          = 1'($urandom_range(0, 1));
    w.init_low           = $urandom();
    w.init_bits_left     = 6'($urandom_range(0, 63));
    w.init_pending_byte  = 8'($urandom_range(0, 255));
    w.init_pending_count = 8'($urandom_range(0, 255));
    w.init_zero_run      = 2'($urandom_range(0, 3));
    w.stream_id          = 5'($urandom_range(0, 31));
    return w;
  endfunction

  function automatic acbo_in_t start_cmd(input logic [31:0] lo, input logic [5:0] bl,
                                         input logic [7:0] hb, input logic [7:0] pc,
                                         input logic [1:0] zr, input logic [4:0] sid);
    acbo_in_t w;
    w = rand_word();
    w.command            = CmdStart;
    w.init_low           = lo;
    w.init_bits_left     = bl;
    w.init_pending_byte  = hb;
    w.init_pending_count = pc;
    w.init_zero_run      = zr;
    w.stream_id          = sid;
    return w;
  endfunction

  function automatic acbo_in_t update_cmd(input logic [23:0] add, input logic [3:0] sh,
                                          input logic af);
    acbo_in_t w;
    w = rand_word();
    w.command      = CmdUpdate;
    w.low_add      = add;
    w.shift_amount = sh;
    w.add_first    = af;
    return w;
  endfunction

  function automatic acbo_in_t stop_cmd();
    acbo_in_t w;
    w = rand_word();
    w.command = CmdStop;
    return w;
  endfunction

  function automatic acbo_out_t report_word(input logic [31:0] lo, input logic [5:0] bl,
                                            input logic [7:0] hb, input logic [7:0] pc,
                                            input logic [1:0] zr, input logic [15:0] len,
                                            input logic [4:0] sid);
    acbo_out_t r;
    r = '0;
    r.kind                = KindReport;
    r.last                = 1'b1;
    r.final_low           = lo;
    r.final_bits_left     = bl;
    r.final_pending_byte  = hb;
    r.final_pending_count = pc;
    r.final_zero_run      = zr;
    r.final_length        = len;
    r.done_stream_id      = sid;
    return r;
  endfunction

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offer one word after a gap and hold it until the block takes it. Push stays
  // high on return so that a following word with no gap goes out back to back.
  task automatic offer_word(input acbo_in_t w, input int gap, input bit typed,
                            input int typed_n, input acbo_out_t typed_w);
    @(negedge clk_i);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push        <= 1'b1;
    in_word     <= w;
    typed_now   <= typed;
    typed_n_now <= typed_n;
    typed_w_now <= typed_w;
    do @(posedge clk_i); while (full);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic acbo_out_t byte_word(input logic [7:0] b);
    acbo_out_t r;
    r = '0;
    r.kind      = KindByte;
    r.data_byte = b;
    return r;
  endfunction

  // Send one stream byte through emulation prevention: after two zero bytes,
  // a byte of 0..3 is preceded by an escape byte.
  function automatic void put_stream_byte(input logic [7:0] b);
    if (p_zrun == ZeroRunMax && b[7:2] == 6'd0) begin
      step_words.push_back(byte_word(EscByte));
      step_words.push_back(byte_word(b));
      p_zrun = (b == ZeroByte) ? 2'd1 : 2'd0;
      p_len  = p_len + 16'd2;
    end else begin
      step_words.push_back(byte_word(b));
      p_zrun = (b == ZeroByte) ? p_zrun + 2'd1 : 2'd0;
      p_len  = p_len + 16'd1;
    end
  endfunction

  // Advance the predicted coder by one command and leave its words in step_words.
  function automatic void apply_command(input acbo_in_t w);
    acbo_out_t   tail;
    logic [5:0]  bits_n;
    logic [5:0]  lead_sh;
    logic [31:0] low_n;
    logic [31:0] keep;
    logic [8:0]  lead;
    logic [7:0]  first_b;
    logic [7:0]  run_b;
    int          reps;
    bit          extract;
    step_words.delete();
    case (w.command)
      CmdStart: begin
        p_low   = w.init_low;
        p_bits  = w.init_bits_left;
        p_held  = w.init_pending_byte;
        p_count = w.init_pending_count;
        p_zrun  = (w.init_zero_run > ZeroRunMax) ? ZeroRunMax : w.init_zero_run;
        p_sid   = w.stream_id;
        p_len   = '0;
      end
      CmdStop: begin
        step_words.push_back(report_word(p_low, p_bits, p_held, p_count, p_zrun, p_len,
                                         p_sid));
      end
      CmdUpdate: begin
        // Bits-left and the lead position both wrap at six bits.
        bits_n  = p_bits - 6'(w.shift_amount);
        lead_sh = 6'(LeadBase) - bits_n;
        extract = (bits_n < ExtractBelow);
        keep    = extract ? (LowMask >> bits_n) : '1;
        if (extract) bits_n = bits_n + BitsRefill;
        p_bits = bits_n;
        if (w.add_first) low_n = (p_low + 32'(w.low_add)) << w.shift_amount;
        else low_n = (p_low << w.shift_amount) + 32'(w.low_add);
        lead  = (lead_sh < 6'd32) ? 9'(low_n >> lead_sh) : 9'd0;
        p_low = low_n & keep;
        if (extract && lead == {1'b0, FfByte}) begin
          // A lead of all ones only lengthens the outstanding run.
          p_count = p_count + 8'd1;
        end else if (extract) begin
          first_b = p_held + 8'(lead[8]);
          run_b   = lead[8] ? ZeroByte : FfByte;
          p_held  = lead[7:0];
          if (p_count != 8'd0) begin
            reps = int'(p_count) - 1;
            if (reps > RepeatLimit) reps = RepeatLimit;
            put_stream_byte(first_b);
            repeat (reps) put_stream_byte(run_b);
          end
          p_count = 8'd1;
          if (step_words.size() != 0) begin
            tail = step_words.pop_back();
            tail.last = 1'b1;
            step_words.push_back(tail);
          end
        end
      end
      default: ;  // unused code: no word, state untouched
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: check popped words, then predict accepted ones
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : score
    acbo_out_t exp_w;
    if (rst_ni && pop && !empty) begin
      words_taken++;
      if (awaited_words.size() == 0) begin
        $error("unexpected word: %h", out_word);
        fail_count++;
      end else begin
        exp_w = awaited_words.pop_front();
        if (out_word.kind !== exp_w.kind) begin
          $error("kind: expected %0h, actual %0h", exp_w.kind, out_word.kind);
          fail_count++;
        end
        if (out_word.data_byte !== exp_w.data_byte) begin
          $error("data_byte: expected %0h, actual %0h", exp_w.data_byte, out_word.data_byte);
          fail_count++;
        end
        if (out_word.last !== exp_w.last) begin
          $error("last: expected %0h, actual %0h", exp_w.last, out_word.last);
          fail_count++;
        end
        if (out_word.final_low !== exp_w.final_low) begin
          $error("final_low: expected %0h, actual %0h", exp_w.final_low, out_word.final_low);
          fail_count++;
        end
        if (out_word.final_bits_left !== exp_w.final_bits_left) begin
          $error("final_bits_left: expected %0h, actual %0h", exp_w.final_bits_left,
                 out_word.final_bits_left);
          fail_count++;
        end
        if (out_word.final_pending_byte !== exp_w.final_pending_byte) begin
          $error("final_pending_byte: expected %0h, actual %0h", exp_w.final_pending_byte,
                 out_word.final_pending_byte);
          fail_count++;
        end
        if (out_word.final_pending_count !== exp_w.final_pending_count) begin
          $error("final_pending_count: expected %0h, actual %0h", exp_w.final_pending_count,
                 out_word.final_pending_count);
          fail_count++;
        end
        if (out_word.final_zero_run !== exp_w.final_zero_run) begin
          $error("final_zero_run: expected %0h, actual %0h", exp_w.final_zero_run,
                 out_word.final_zero_run);
          fail_count++;
        end
        if (out_word.final_length !== exp_w.final_length) begin
          $error("final_length: expected %0h, actual %0h", exp_w.final_length,
                 out_word.final_length);
          fail_count++;
        end
        if (out_word.done_stream_id !== exp_w.done_stream_id) begin
          $error("done_stream_id: expected %0h, actual %0h", exp_w.done_stream_id,
                 out_word.done_stream_id);
          fail_count++;
        end
      end
    end
    if (rst_ni && push && !full) begin
      // Always advance the predictor; a typed row only replaces its words.
      apply_command(in_word);
      if (typed_now) begin
        step_words.delete();
        if (typed_n_now != 0) step_words.push_back(typed_w_now);
      end
      foreach (step_words[i]) awaited_words.push_back(step_words[i]);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random pop gaps, flood stretches, and one long hold-off
  // ---------------------------------------------------------------------------

  always begin : pop_driver
    int  gap;
    int  flood_left;
    bit  held_long;
    @(negedge clk_i);
    if (flood_left > 0) begin
      gap = 0;
      flood_left--;
    end else begin
      gap = idle_cycles();
      if ($urandom_range(0, 99) < 3) flood_left = 30;
    end
    // Hold off once the stream is well under way, so the job queue fills and
    // full rises while the sender keeps offering.
    if (!held_long && words_taken >= 80) begin
      gap = LongHold;
      held_long = 1'b1;
    end
    if (gap != 0) begin
      pop <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pop <= 1'b1;
    do @(posedge clk_i); while (empty);
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, random streams, drain
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    dir_row_t  rows[$];
    acbo_in_t  w;
    acbo_out_t zero_report;
    int        sent;
    int        steps;
    int        sel;
    bit        burst;
    bit        drained;

    zero_report = report_word('0, '0, '0, '0, '0, '0, '0);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Report straight after reset, then the ignored code with every bit set.
    rows.push_back(dir_row_t'{stop_cmd(), 1'b1, 1, zero_report});
    rows.push_back(dir_row_t'{acbo_in_t'('1), 1'b1, 0, '0});
    // Updates on the reset state, before any start.
    rows.push_back(dir_row_t'{update_cmd(24'hff_ffff, 4'd0, 1'b0), 1'b0, 0, '0});
    rows.push_back(dir_row_t'{update_cmd(24'h12_3456, 4'd8, 1'b1), 1'b0, 0, '0});
    rows.push_back(dir_row_t'{stop_cmd(), 1'b0, 0, '0});
    // All-ones start: zero run of three loads as two.
    rows.push_back(dir_row_t'{start_cmd('1, 6'd63, 8'hff, 8'hff, 2'd3, 5'd31),
                              1'b0, 0, '0});
    rows.push_back(dir_row_t'{stop_cmd(), 1'b1, 1,
                              report_word('1, 6'd63, 8'hff, 8'hff, ZeroRunMax, '0, 5'd31)});
    // Low wraps past 2^32 on add-then-shift.
    rows.push_back(dir_row_t'{update_cmd(24'hff_ffff, 4'd8, 1'b1), 1'b0, 0, '0});
    rows.push_back(dir_row_t'{stop_cmd(), 1'b0, 0, '0});
    // All-zero start, then bits-left wraps below zero.
    rows.push_back(dir_row_t'{start_cmd('0, '0, '0, '0, '0, '0), 1'b0, 0, '0});
    rows.push_back(dir_row_t'{stop_cmd(), 1'b1, 1, zero_report});
    rows.push_back(dir_row_t'{update_cmd(24'h00_0000, 4'd8, 1'b0), 1'b0, 0, '0});
    rows.push_back(dir_row_t'{stop_cmd(), 1'b0, 0, '0});
    // Carry into an all-ones held byte with a long outstanding run behind
    // two zero bytes: the run is capped and zero bytes pick up escapes.
    rows.push_back(dir_row_t'{start_cmd(32'h0010_0000, 6'd12, 8'hff, 8'hff, 2'd2, 5'd5),
                              1'b0, 0, '0});
    rows.push_back(dir_row_t'{update_cmd(24'h00_0000, 4'd1, 1'b0), 1'b0, 0, '0});
    rows.push_back(dir_row_t'{stop_cmd(), 1'b0, 0, '0});
    // Lead of all ones lengthens the run, a zero lead flushes it with an
    // escape, then a carried lead.
    rows.push_back(dir_row_t'{start_cmd(32'h000f_f000, 6'd12, 8'h00, 8'd1, 2'd2, 5'd9),
                              1'b0, 0, '0});
    rows.push_back(dir_row_t'{update_cmd(24'h00_0000, 4'd1, 1'b0), 1'b0, 0, '0});
    rows.push_back(dir_row_t'{update_cmd(24'h00_0400, 4'd8, 1'b0), 1'b0, 0, '0});
    rows.push_back(dir_row_t'{update_cmd(24'h00_2000, 4'd8, 1'b1), 1'b0, 0, '0});
    rows.push_back(dir_row_t'{stop_cmd(), 1'b0, 0, '0});

    foreach (rows[i]) offer_word(rows[i].word, idle_cycles(), rows[i].typed,
                                 rows[i].typed_n, rows[i].typed_w);

    // Random streams: mostly start, a run of updates and a stop; the rest is noise.
    sent = 0;
    drained = 1'b0;
    while (sent < RandomItems) begin
      // Pause once mid-run until every awaited word has come back.
      if (!drained && sent >= RandomItems / 2) begin
        @(negedge clk_i);
        push <= 1'b0;
        while (awaited_words.size() != 0) @(negedge clk_i);
        drained = 1'b1;
      end
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        w = rand_word();
        offer_word(w, idle_cycles(), 1'b0, 0, '0);
        if (w.command != CmdUnused) sent++;
      end else begin
        w = start_cmd($urandom() >> $urandom_range(0, 31),
                      ($urandom_range(0, 9) < 8) ? 6'($urandom_range(12, 20))
                                                 : 6'($urandom_range(0, 63)),
                      8'($urandom_range(0, 255)),
                      ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                                  : 8'($urandom_range(0, 255)),
                      2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
        offer_word(w, burst ? 0 : idle_cycles(), 1'b0, 0, '0);
        sent++;
        steps = $urandom_range(1, 12);
        repeat (steps) begin
          sel = $urandom_range(0, 3);
          w = update_cmd((sel == 0) ? 24'd0 :
                         (sel == 3) ? 24'($urandom()) :
                                      24'($urandom()) >> $urandom_range(0, 23),
                         4'($urandom_range(0, 8)), 1'($urandom_range(0, 1)));
          offer_word(w, burst ? 0 : idle_cycles(), 1'b0, 0, '0);
          sent++;
        end
        if ($urandom_range(0, 7) != 0) begin
          offer_word(stop_cmd(), burst ? 0 : idle_cycles(), 1'b0, 0, '0);
          sent++;
        end
      end
    end

    @(negedge clk_i);
    push <= 1'b0;
    while (awaited_words.size() != 0) @(negedge clk_i);
    // Leave room for any stray word to show up and be flagged.
    repeat (SettleTail) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
